### src/pnft_pkg.sv
// Shared constants for the per-key note FIFO tracker.
package pnft_pkg;

	localparam int NUM_TRACKS   = 4;
	localparam int NUM_CHANNELS = 16;
	localparam int NUM_KEYS     = 128;
	localparam int POOL_ENTRIES = 1024;

	localparam int TRACK_W = 2;
	localparam int CHAN_W  = 4;
	localparam int KEY_W   = 7;
	localparam int NUM_W   = 32;

	localparam int NUM_QUEUES = NUM_TRACKS * NUM_CHANNELS * NUM_KEYS;
	localparam int QADDR_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int EIDX_W     = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int CNT_W      = $clog2(POOL_ENTRIES + 1);

	localparam logic REQ_KEY_DOWN = 1'b0;
	localparam logic REQ_KEY_UP   = 1'b1;

endpackage

### src/per_key_note_fifo_tracker.sv
// Per-key note FIFO tracker: linked-list queues over a shared entry pool.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | req_type, track, channel, key
//  out     | out_valid / out_ready| note_number, found, overflow
//
// After reset a clearing pass walks the queue memory, one entry per cycle
// (all NUM_QUEUES entries, 8192 here); in_ready stays low until it ends.
// One transaction at a time: a key down passes ST_READ, and ST_LINK as well when it
// appends to a non-empty queue; a key up passes ST_READ and ST_POP (queue read, then
// entry read), or only ST_READ on an empty queue.
// These steps are set by the dependent reads of the queue and entry memories.
// A stalled output holds the finishing step; the next input is still taken
// while a result waits in the output register.
module per_key_note_fifo_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [pnft_pkg::TRACK_W-1:0]  track,
	input  logic [pnft_pkg::CHAN_W-1:0]   channel,
	input  logic [pnft_pkg::KEY_W-1:0]    key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pnft_pkg::NUM_W-1:0]    note_number,
	output logic                          found,
	output logic                          overflow
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_POP   = 5'b01000,
		ST_LINK  = 5'b10000
	} state_t;

	typedef struct packed {
		logic                          valid;
		logic [pnft_pkg::EIDX_W-1:0]   head;
		logic [pnft_pkg::EIDX_W-1:0]   tail;
	} qword_t;

	state_t state_q, state_nx;
	logic [pnft_pkg::QADDR_W-1:0] clr_q;
	logic [pnft_pkg::NUM_W-1:0]   cnt_q;
	logic [pnft_pkg::CNT_W-1:0]   fresh_q;
	logic [pnft_pkg::CNT_W-1:0]   free_cnt_q;
	logic [pnft_pkg::EIDX_W-1:0]  free_top_q;

	logic                         req_s1;
	logic                         ok_s1;
	logic [pnft_pkg::QADDR_W-1:0] qa_s1;
	qword_t                       q_rd_s1;
	logic [pnft_pkg::EIDX_W-1:0]  nxt_rd_s1;
	logic [pnft_pkg::NUM_W-1:0]   num_rd_s1;

	logic [pnft_pkg::EIDX_W-1:0]  link_addr_q;
	logic [pnft_pkg::EIDX_W-1:0]  link_data_q;

	logic                         out_valid_q;
	logic [pnft_pkg::NUM_W-1:0]   note_q;
	logic                         found_q;
	logic                         ovf_q;

	// memories
	qword_t                       q_mem   [pnft_pkg::NUM_QUEUES];
	logic [pnft_pkg::EIDX_W-1:0]  nxt_mem [pnft_pkg::POOL_ENTRIES];
	logic [pnft_pkg::NUM_W-1:0]   num_mem [pnft_pkg::POOL_ENTRIES];

	logic                         accept;
	logic [pnft_pkg::QADDR_W-1:0] in_qa;
	logic                         out_free;
	logic                         from_fresh;
	logic [pnft_pkg::EIDX_W-1:0]  alloc_e;
	logic [pnft_pkg::NUM_W-1:0]   cnt_inc;

	logic                         q_we;
	logic [pnft_pkg::QADDR_W-1:0] q_wa;
	qword_t                       q_wd;
	logic                         e_re;
	logic [pnft_pkg::EIDX_W-1:0]  e_ra;
	logic                         nxt_we;
	logic                         num_we;
	logic [pnft_pkg::EIDX_W-1:0]  e_wa;
	logic [pnft_pkg::EIDX_W-1:0]  nxt_wd;

	logic                         res_load;
	logic [pnft_pkg::NUM_W-1:0]   res_note;
	logic                         res_found;
	logic                         res_ovf;
	logic                         alloc_do;
	logic                         free_do;
	logic                         link_set;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign in_qa = pnft_pkg::QADDR_W'(
		32'(track) * pnft_pkg::NUM_CHANNELS * pnft_pkg::NUM_KEYS
		+ 32'(channel) * pnft_pkg::NUM_KEYS + 32'(key));

	assign from_fresh = fresh_q < pnft_pkg::CNT_W'(pnft_pkg::POOL_ENTRIES);
	assign alloc_e    = from_fresh ? fresh_q[pnft_pkg::EIDX_W-1:0] : free_top_q;
	assign cnt_inc    = cnt_q + 1'b1;

	always_comb begin
		state_nx  = state_q;
		q_we      = 1'b0;
		q_wa      = qa_s1;
		q_wd      = '0;
		e_re      = 1'b0;
		e_ra      = free_top_q;
		nxt_we    = 1'b0;
		num_we    = 1'b0;
		e_wa      = alloc_e;
		nxt_wd    = link_data_q;
		res_load  = 1'b0;
		res_note  = '0;
		res_found = 1'b0;
		res_ovf   = 1'b0;
		alloc_do  = 1'b0;
		free_do   = 1'b0;
		link_set  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				q_we = 1'b1;
				q_wa = clr_q;
				if (clr_q == pnft_pkg::QADDR_W'(pnft_pkg::NUM_QUEUES - 1))
					state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				// free-list successor is fetched together with the queue word
				e_re = accept;
				if (accept)
					state_nx = ST_READ;
			end
			ST_READ: begin
				if (out_free) begin
					if (!ok_s1) begin
						res_load = 1'b1;
						state_nx = ST_IDLE;
					end else if (req_s1 == pnft_pkg::REQ_KEY_DOWN) begin
						res_load = 1'b1;
						if (free_cnt_q == '0) begin
							res_ovf  = 1'b1;
							state_nx = ST_IDLE;
						end else begin
							alloc_do = 1'b1;
							res_note = cnt_inc;
							num_we   = 1'b1;
							q_we     = 1'b1;
							q_wd.valid = 1'b1;
							q_wd.tail  = alloc_e;
							q_wd.head  = q_rd_s1.valid ? q_rd_s1.head : alloc_e;
							if (q_rd_s1.valid) begin
								link_set = 1'b1;
								state_nx = ST_LINK;
							end else begin
								state_nx = ST_IDLE;
							end
						end
					end else if (!q_rd_s1.valid) begin
						res_load = 1'b1;
						state_nx = ST_IDLE;
					end else begin
						e_re     = 1'b1;
						e_ra     = q_rd_s1.head;
						state_nx = ST_POP;
					end
				end
			end
			ST_POP: begin
				if (out_free) begin
					res_load  = 1'b1;
					res_found = 1'b1;
					res_note  = num_rd_s1;
					free_do   = 1'b1;
					q_we      = 1'b1;
					if (q_rd_s1.head != q_rd_s1.tail) begin
						q_wd.valid = 1'b1;
						q_wd.head  = nxt_rd_s1;
						q_wd.tail  = q_rd_s1.tail;
					end
					// freed entry is pushed on the free list through its next field
					nxt_we   = 1'b1;
					e_wa     = q_rd_s1.head;
					nxt_wd   = free_top_q;
					state_nx = ST_IDLE;
				end
			end
			ST_LINK: begin
				nxt_we   = 1'b1;
				e_wa     = link_addr_q;
				nxt_wd   = link_data_q;
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// queue memory: head, tail and valid per queue
	always_ff @(posedge clk) begin
		if (q_we)
			q_mem[q_wa] <= q_wd;
		if (accept)
			q_rd_s1 <= q_mem[in_qa];
	end

	// entry memory: next and number fields with separate write enables
	always_ff @(posedge clk) begin
		if (nxt_we)
			nxt_mem[e_wa] <= nxt_wd;
		if (num_we)
			num_mem[e_wa] <= cnt_inc;
		if (e_re) begin
			nxt_rd_s1 <= nxt_mem[e_ra];
			num_rd_s1 <= num_mem[e_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			fresh_q     <= '0;
			free_cnt_q  <= pnft_pkg::CNT_W'(pnft_pkg::POOL_ENTRIES);
			free_top_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (alloc_do) begin
				cnt_q      <= cnt_inc;
				free_cnt_q <= free_cnt_q - 1'b1;
				if (from_fresh)
					fresh_q <= fresh_q + 1'b1;
				else
					free_top_q <= nxt_rd_s1;
			end
			if (free_do) begin
				free_cnt_q <= free_cnt_q + 1'b1;
				free_top_q <= q_rd_s1.head;
			end
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_type;
			ok_s1  <= 32'(track) < pnft_pkg::NUM_TRACKS;
			qa_s1  <= in_qa;
		end
		if (link_set) begin
			link_addr_q <= q_rd_s1.tail;
			link_data_q <= alloc_e;
		end
		if (res_load) begin
			note_q  <= res_note;
			found_q <= res_found;
			ovf_q   <= res_ovf;
		end
	end

	assign out_valid   = out_valid_q;
	assign note_number = note_q;
	assign found       = found_q;
	assign overflow    = ovf_q;

endmodule

### src/pnft_checker.sv
// Port-level checker for the note tracker, bound to the top level.
module pnft_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [pnft_pkg::NUM_W-1:0]  note_number,
	input logic                        found,
	input logic                        overflow
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(note_number)
			&& $stable(found) && $stable(overflow))
		else $error("result changed while stalled");

	// one transaction in flight: no accept on the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && overflow))
		else $error("found and overflow both set");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> note_number == '0)
		else $error("dropped key down carries a number");

endmodule

bind per_key_note_fifo_tracker pnft_checker u_pnft_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.note_number (note_number),
	.found       (found),
	.overflow    (overflow)
);

### sim/tb_per_key_note_fifo_tracker.sv
// Testbench for the per-key note FIFO tracker: directed table, then random traffic.
module tb_per_key_note_fifo_tracker;

	localparam int WATCHDOG_LIMIT = 30000;
	localparam int RANDOM_ITEMS   = 650;
	localparam int WORK_SET       = 12;

	typedef struct packed {
		logic [pnft_pkg::NUM_W-1:0] number;
		logic                       found;
		logic                       overflow;
	} note_result_t;

	typedef struct packed {
		logic                         typed;
		logic                         req;
		logic [pnft_pkg::TRACK_W-1:0] trk;
		logic [pnft_pkg::CHAN_W-1:0]  chn;
		logic [pnft_pkg::KEY_W-1:0]   k;
		logic [pnft_pkg::NUM_W-1:0]   number;
		logic                         found;
		logic                         overflow;
	} note_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         req_type = pnft_pkg::REQ_KEY_DOWN;
	logic [pnft_pkg::TRACK_W-1:0] track = '0;
	logic [pnft_pkg::CHAN_W-1:0]  channel = '0;
	logic [pnft_pkg::KEY_W-1:0]   key = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [pnft_pkg::NUM_W-1:0]   note_number;
	logic                         found;
	logic                         overflow;

	per_key_note_fifo_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.track(track),
		.channel(channel),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.note_number(note_number),
		.found(found),
		.overflow(overflow)
	);

	always #5 clk = ~clk;

	// Shadow of the tracker state
	logic [pnft_pkg::NUM_W-1:0]  note_ctr = '0;
	bit                          q_live [pnft_pkg::NUM_QUEUES];
	logic [pnft_pkg::EIDX_W-1:0] q_head [pnft_pkg::NUM_QUEUES];
	logic [pnft_pkg::EIDX_W-1:0] q_tail [pnft_pkg::NUM_QUEUES];
	logic [pnft_pkg::EIDX_W-1:0] ent_next [pnft_pkg::POOL_ENTRIES];
	logic [pnft_pkg::NUM_W-1:0]  ent_num [pnft_pkg::POOL_ENTRIES];
	logic [pnft_pkg::EIDX_W-1:0] free_stk [pnft_pkg::POOL_ENTRIES];
	int unsigned                 free_cnt = pnft_pkg::POOL_ENTRIES;

	note_result_t pending_results[$];
	int           errors = 0;
	int           idle_cycles = 0;
	bit           calm = 1'b0;
	int unsigned  hold_left = 0;
	int unsigned  work_set [WORK_SET];
	note_row_t    directed_rows [0:19];

	function automatic int unsigned stall_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned pick_gap();
		if (calm || $urandom_range(0, 99) < 60)
			return 0;
		return stall_len();
	endfunction

	function automatic note_result_t apply_note_event(input logic rq,
			input logic [pnft_pkg::TRACK_W-1:0] tr,
			input logic [pnft_pkg::CHAN_W-1:0] ch, input logic [pnft_pkg::KEY_W-1:0] k);
		note_result_t                r;
		int unsigned                 q;
		logic [pnft_pkg::EIDX_W-1:0] e;
		r = '0;
		if (int'(tr) >= pnft_pkg::NUM_TRACKS)
			return r;
		q = (int'(tr) * pnft_pkg::NUM_CHANNELS + int'(ch)) * pnft_pkg::NUM_KEYS + int'(k);
		if (rq == pnft_pkg::REQ_KEY_DOWN) begin
			if (free_cnt == 0) begin
				r.overflow = 1'b1;
			end else begin
				free_cnt--;
				e = free_stk[free_cnt];
				note_ctr = note_ctr + 1'b1;
				r.number = note_ctr;
				ent_num[e] = note_ctr;
				ent_next[e] = '0;
				if (q_live[q]) begin
					ent_next[q_tail[q]] = e;
				end else begin
					q_live[q] = 1'b1;
					q_head[q] = e;
				end
				q_tail[q] = e;
			end
		end else if (q_live[q]) begin
			e = q_head[q];
			r.number = ent_num[e];
			r.found = 1'b1;
			if (e == q_tail[q])
				q_live[q] = 1'b0;
			else
				q_head[q] = ent_next[e];
			if (free_cnt < pnft_pkg::POOL_ENTRIES) begin
				free_stk[free_cnt] = e;
				free_cnt++;
			end
		end
		return r;
	endfunction

	// Drive one transaction; a typed expectation replaces the predicted one.
	task automatic send_note(input logic rq, input logic [pnft_pkg::TRACK_W-1:0] tr,
			input logic [pnft_pkg::CHAN_W-1:0] ch, input logic [pnft_pkg::KEY_W-1:0] k,
			input bit typed, input note_result_t typed_res);
		int unsigned  gap;
		note_result_t r;
		gap = pick_gap();
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= rq;
		track <= tr;
		channel <= ch;
		key <= k;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = apply_note_event(rq, tr, ch, k);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic send_on_queue(input logic rq, input int unsigned q);
		send_note(rq, pnft_pkg::TRACK_W'(q / (pnft_pkg::NUM_CHANNELS * pnft_pkg::NUM_KEYS)),
			pnft_pkg::CHAN_W'((q / pnft_pkg::NUM_KEYS) % pnft_pkg::NUM_CHANNELS),
			pnft_pkg::KEY_W'(q % pnft_pkg::NUM_KEYS), 1'b0, '0);
	endtask

	task automatic refresh_work_set();
		foreach (work_set[i]) work_set[i] = $urandom_range(0, pnft_pkg::NUM_QUEUES - 1);
	endtask

	always @(negedge clk) begin
		if (calm) begin
			hold_left = 0;
			out_ready <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 30) begin
			hold_left = stall_len() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		note_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no transaction pending: note_number %0d found %0b overflow %0b",
					note_number, found, overflow);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (note_number !== want.number) begin
					$error("note_number: expected %0d, got %0d", want.number, note_number);
					errors++;
				end
				if (found !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, found);
					errors++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, overflow);
					errors++;
				end
			end
		end
	end

	// Watchdog: also covers the queue clearing pass after reset
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned  q;
		logic         rq;
		note_result_t typed_res;
		foreach (free_stk[i]) free_stk[i] = pnft_pkg::EIDX_W'(i);
		// typed, req, track, channel, key, note_number, found, overflow
		directed_rows = '{
			'{1'b1, pnft_pkg::REQ_KEY_UP,   2'd0, 4'd0,  7'd0,   32'd0, 1'b0, 1'b0},
			'{1'b1, pnft_pkg::REQ_KEY_UP,   2'd3, 4'd15, 7'd127, 32'd0, 1'b0, 1'b0},
			'{1'b1, pnft_pkg::REQ_KEY_DOWN, 2'd0, 4'd0,  7'd0,   32'd1, 1'b0, 1'b0},
			'{1'b1, pnft_pkg::REQ_KEY_DOWN, 2'd0, 4'd0,  7'd0,   32'd2, 1'b0, 1'b0},
			'{1'b1, pnft_pkg::REQ_KEY_DOWN, 2'd3, 4'd15, 7'd127, 32'd3, 1'b0, 1'b0},
			'{1'b1, pnft_pkg::REQ_KEY_UP,   2'd0, 4'd0,  7'd0,   32'd1, 1'b1, 1'b0},
			'{1'b1, pnft_pkg::REQ_KEY_DOWN, 2'd0, 4'd0,  7'd0,   32'd4, 1'b0, 1'b0},
			'{1'b1, pnft_pkg::REQ_KEY_UP,   2'd0, 4'd0,  7'd0,   32'd2, 1'b1, 1'b0},
			'{1'b1, pnft_pkg::REQ_KEY_UP,   2'd0, 4'd0,  7'd0,   32'd4, 1'b1, 1'b0},
			'{1'b1, pnft_pkg::REQ_KEY_UP,   2'd0, 4'd0,  7'd0,   32'd0, 1'b0, 1'b0},
			'{1'b1, pnft_pkg::REQ_KEY_UP,   2'd3, 4'd15, 7'd127, 32'd3, 1'b1, 1'b0},
			'{1'b1, pnft_pkg::REQ_KEY_UP,   2'd3, 4'd15, 7'd127, 32'd0, 1'b0, 1'b0},
			'{1'b0, pnft_pkg::REQ_KEY_DOWN, 2'd1, 4'd10, 7'd85,  32'd0, 1'b0, 1'b0},
			'{1'b0, pnft_pkg::REQ_KEY_DOWN, 2'd2, 4'd5,  7'd42,  32'd0, 1'b0, 1'b0},
			'{1'b0, pnft_pkg::REQ_KEY_DOWN, 2'd1, 4'd10, 7'd85,  32'd0, 1'b0, 1'b0},
			'{1'b0, pnft_pkg::REQ_KEY_UP,   2'd2, 4'd5,  7'd42,  32'd0, 1'b0, 1'b0},
			'{1'b0, pnft_pkg::REQ_KEY_UP,   2'd1, 4'd10, 7'd85,  32'd0, 1'b0, 1'b0},
			'{1'b0, pnft_pkg::REQ_KEY_DOWN, 2'd1, 4'd10, 7'd85,  32'd0, 1'b0, 1'b0},
			'{1'b0, pnft_pkg::REQ_KEY_UP,   2'd1, 4'd10, 7'd85,  32'd0, 1'b0, 1'b0},
			'{1'b0, pnft_pkg::REQ_KEY_UP,   2'd1, 4'd10, 7'd85,  32'd0, 1'b0, 1'b0}
		};
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			typed_res.number = directed_rows[i].number;
			typed_res.found = directed_rows[i].found;
			typed_res.overflow = directed_rows[i].overflow;
			send_note(directed_rows[i].req, directed_rows[i].trk, directed_rows[i].chn,
				directed_rows[i].k, directed_rows[i].typed, typed_res);
		end

		// Mostly note on/off pairs on a few keys so queues get deep; the rest is noise
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				refresh_work_set();
			calm = (n % 150) >= 110;
			if ($urandom_range(0, 99) < 80) begin
				q = work_set[$urandom_range(0, WORK_SET - 1)];
				if (q_live[q])
					rq = ($urandom_range(0, 1) == 0) ? pnft_pkg::REQ_KEY_DOWN
						: pnft_pkg::REQ_KEY_UP;
				else
					rq = ($urandom_range(0, 99) < 75) ? pnft_pkg::REQ_KEY_DOWN
						: pnft_pkg::REQ_KEY_UP;
			end else begin
				q = $urandom_range(0, pnft_pkg::NUM_QUEUES - 1);
				rq = ($urandom_range(0, 1) == 0) ? pnft_pkg::REQ_KEY_DOWN : pnft_pkg::REQ_KEY_UP;
			end
			send_on_queue(rq, q);
		end
		calm = 1'b0;

		repeat (20) send_on_queue(($urandom_range(0, 1) == 0) ? pnft_pkg::REQ_KEY_DOWN
			: pnft_pkg::REQ_KEY_UP, work_set[$urandom_range(0, 1)]);

		@(negedge clk) in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
